// ----- rtl/core/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and helpers for the command stream parser.
// ----------------------------------------------------------------------------
package csp_pkg;

   // Field widths
   localparam int ByteW   = 8;
   localparam int PosW    = 16;
   localparam int KindW   = 3;
   localparam int PhaseW  = 2;
   localparam int ClassW  = 3;

   // Parser phase codes
   localparam logic [PhaseW-1:0] PH_OPCODE = 2'd0;
   localparam logic [PhaseW-1:0] PH_LENGTH = 2'd1;
   localparam logic [PhaseW-1:0] PH_ARGS   = 2'd2;
   localparam logic [PhaseW-1:0] PH_ENDED  = 2'd3;

   // Result kind codes
   localparam logic [KindW-1:0] K_HEADER    = 3'd0;
   localparam logic [KindW-1:0] K_AWAIT_LEN = 3'd1;
   localparam logic [KindW-1:0] K_ARG       = 3'd2;
   localparam logic [KindW-1:0] K_END       = 3'd3;
   localparam logic [KindW-1:0] K_TRUNC     = 3'd4;
   localparam logic [KindW-1:0] K_IGNORED   = 3'd5;

   // Opcode classes (top three bits of the opcode)
   localparam logic [ClassW-1:0] CLS_NONE = 3'h0;  // 0x00
   localparam logic [ClassW-1:0] CLS_2    = 3'h1;  // 0x20
   localparam logic [ClassW-1:0] CLS_4    = 3'h2;  // 0x40
   localparam logic [ClassW-1:0] CLS_8    = 3'h3;  // 0x60
   localparam logic [ClassW-1:0] CLS_12   = 3'h4;  // 0x80
   localparam logic [ClassW-1:0] CLS_16   = 3'h5;  // 0xa0
   localparam logic [ClassW-1:0] CLS_LEN  = 3'h6;  // 0xc0
   localparam logic [ClassW-1:0] CLS_END  = 3'h7;  // 0xe0

   // Parser state carried between bytes
   typedef struct packed {
      logic [PosW-1:0]   position;
      logic [PhaseW-1:0] phase;
      logic [ByteW-1:0]  args_left;
      logic [ByteW-1:0]  arg_counter;
      logic [ByteW-1:0]  current_opcode;
      logic [ByteW-1:0]  current_count;
   } parse_state_type;

   // One classified result
   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [ByteW-1:0] opcode_value;
      logic [ByteW-1:0] arg_count;
      logic [ByteW-1:0] arg_byte;
      logic [ByteW-1:0] arg_index;
      logic             last_of_command;
   } result_type;

   // Fixed argument count of an opcode class
   function automatic logic [ByteW-1:0] class_arg_count(input logic [ClassW-1:0] cls);
      logic [ByteW-1:0] n;
      case (cls)
         CLS_2:   n = 8'd2;
         CLS_4:   n = 8'd4;
         CLS_8:   n = 8'd8;
         CLS_12:  n = 8'd12;
         CLS_16:  n = 8'd16;
         default: n = 8'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/core/csp_if.sv -----
// ----------------------------------------------------------------------------
// csp_if
// Valid/ready channel interfaces for the command stream parser.
// ----------------------------------------------------------------------------

// Command byte channel
interface csp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_buffer;

   modport source (output valid, output data_byte, output first_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input first_of_buffer, output ready);
endinterface

// Classified result channel
interface csp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] opcode_value;
   logic [7:0] arg_count;
   logic [7:0] arg_byte;
   logic [7:0] arg_index;
   logic       last_of_command;

   modport source (output valid, output kind, output opcode_value, output arg_count,
                   output arg_byte, output arg_index, output last_of_command,
                   input ready);
   modport sink   (input valid, input kind, input opcode_value, input arg_count,
                   input arg_byte, input arg_index, input last_of_command,
                   output ready);
endinterface

// Buffer length register write channel
interface csp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/command_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// command_stream_parser_top
// Byte-serial parser of opcode-plus-argument command buffers.
// ----------------------------------------------------------------------------
// One command byte is taken per clock while the result register can load, and each byte gives exactly one
// classified result, which appears on the result channel on the cycle after
// the byte is taken. The parser state (position, phase, argument counters)
// updates in the same cycle the byte is taken, and a one-entry result
// register lets a new byte in whenever the held result is empty or is being
// taken, so a steady stream runs at one byte per cycle. The buffer length
// register is written through the csr channel, which is always ready, and
// should be written only while no byte is in flight.
// ----------------------------------------------------------------------------
module command_stream_parser_top
   import csp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   csp_req_if.sink   req,
   csp_rsp_if.source rsp,
   csp_csr_if.sink   csr
);

   parse_state_type state_ff;
   parse_state_type state_in;
   logic [PosW-1:0] buf_len_ff;
   result_type      step_result;
   logic            can_load;
   logic            accept;

   // Buffer length register
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff <= '0;
      end else if (csr.valid) begin
         buf_len_ff <= csr.data;
      end
   end

   // Input handshake
   assign req.ready = can_load;
   assign accept    = req.valid && can_load;

   // Per-byte parse logic
   csp_step u_step (
      .cur_state       (state_ff),
      .buf_len         (buf_len_ff),
      .data_byte       (req.data_byte),
      .first_of_buffer (req.first_of_buffer),
      .nxt_state       (state_in),
      .result          (step_result)
   );

   // Parser state; all-zero is the expect-opcode phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register
   csp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (step_result),
      .can_load  (can_load),
      .rsp       (rsp)
   );

endmodule

// ----- rtl/core/csp_step.sv -----
// ----------------------------------------------------------------------------
// csp_step
// Next-state and result logic for one command byte.
// ----------------------------------------------------------------------------
module csp_step
   import csp_pkg::*;
(
   input  parse_state_type  cur_state,
   input  logic [PosW-1:0]  buf_len,
   input  logic [ByteW-1:0] data_byte,
   input  logic             first_of_buffer,
   output parse_state_type  nxt_state,
   output result_type       result
);

   parse_state_type   base;
   logic [PosW-1:0]   pos_inc;
   logic              room;
   logic [ClassW-1:0] cls;
   logic              do_start;
   logic [ByteW-1:0]  start_n;
   logic [ByteW-1:0]  left_dec;
   logic [PosW:0]     end_pos;

   always_comb begin
      // Restart clears state before the byte is parsed
      if (first_of_buffer) begin
         base = '0;
         base.phase = PH_OPCODE;
      end else begin
         base = cur_state;
      end

      nxt_state = base;
      result    = '0;
      do_start  = 1'b0;
      start_n   = '0;
      pos_inc   = base.position + 16'd1;
      room      = base.position < buf_len;
      cls       = data_byte[ByteW-1 -: ClassW];
      left_dec  = base.args_left - 8'd1;

      case (base.phase)
         PH_OPCODE: begin
            if (!room) begin
               nxt_state.phase = PH_ENDED;
               result.kind     = K_END;
            end else begin
               nxt_state.position       = pos_inc;
               nxt_state.current_opcode = data_byte;
               nxt_state.current_count  = '0;
               result.opcode_value      = data_byte;
               if (data_byte == '0 || cls == CLS_END) begin
                  nxt_state.phase        = PH_ENDED;
                  result.kind            = K_END;
                  result.last_of_command = 1'b1;
               end else if (cls == CLS_LEN) begin
                  if (pos_inc >= buf_len) begin
                     nxt_state.phase = PH_ENDED;
                     result.kind     = K_TRUNC;
                  end else begin
                     nxt_state.phase = PH_LENGTH;
                     result.kind     = K_AWAIT_LEN;
                  end
               end else begin
                  do_start = 1'b1;
                  start_n  = class_arg_count(cls);
               end
            end
         end
         PH_LENGTH: begin
            result.opcode_value = base.current_opcode;
            if (!room) begin
               nxt_state.phase = PH_ENDED;
               result.kind     = K_TRUNC;
            end else begin
               nxt_state.position = pos_inc;
               do_start           = 1'b1;
               start_n            = data_byte;
            end
         end
         PH_ARGS: begin
            result.opcode_value = base.current_opcode;
            result.arg_count    = base.current_count;
            if (!room) begin
               nxt_state.phase = PH_ENDED;
               result.kind     = K_TRUNC;
            end else begin
               nxt_state.position    = pos_inc;
               nxt_state.arg_counter = base.arg_counter + 8'd1;
               nxt_state.args_left   = left_dec;
               if (left_dec == '0) begin
                  nxt_state.phase = PH_OPCODE;
               end
               result.kind            = K_ARG;
               result.arg_byte        = data_byte;
               result.arg_index       = base.arg_counter;
               result.last_of_command = (left_dec == '0);
            end
         end
         default: begin
            result.kind = K_IGNORED;
         end
      endcase

      // Header with a known count: check the arguments fit in the buffer
      end_pos = {1'b0, pos_inc} + {{(PosW + 1 - ByteW){1'b0}}, start_n};
      if (do_start) begin
         nxt_state.current_count = start_n;
         result.arg_count        = start_n;
         if (end_pos > {1'b0, buf_len}) begin
            nxt_state.phase = PH_ENDED;
            result.kind     = K_TRUNC;
         end else begin
            nxt_state.args_left    = start_n;
            nxt_state.arg_counter  = '0;
            nxt_state.phase        = (start_n == '0) ? PH_OPCODE : PH_ARGS;
            result.kind            = K_HEADER;
            result.last_of_command = (start_n == '0);
         end
      end
   end

endmodule

// ----- rtl/core/csp_out_reg.sv -----
// ----------------------------------------------------------------------------
// csp_out_reg
// Result register with valid/ready toward the result channel.
// ----------------------------------------------------------------------------
module csp_out_reg
   import csp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       can_load,
   csp_rsp_if.source  rsp
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Free when empty or when the held transaction leaves this cycle
   assign can_load = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.kind            = data_ff.kind;
   assign rsp.opcode_value    = data_ff.opcode_value;
   assign rsp.arg_count       = data_ff.arg_count;
   assign rsp.arg_byte        = data_ff.arg_byte;
   assign rsp.arg_index       = data_ff.arg_index;
   assign rsp.last_of_command = data_ff.last_of_command;

endmodule
